@@ design/mhpq_pkg.sv @@
`default_nettype none

package mhpq_pkg;

   // sizes of the transferred fields
   localparam int DEPTH_DEFAULT = 64;
   localparam int DATA_W        = 32;
   localparam int COUNT_W       = 7;
   localparam int STATUS_W      = 2;

   // request kinds
   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_REMOVE = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 2'd2;

   // datapath operations issued by the controller
   typedef enum logic [3:0] {
      OP_NONE,
      OP_START,
      OP_UP_CHECK,
      OP_UP_CMP,
      OP_RM_LAST,
      OP_RM_MOVE,
      OP_DN_CHECK,
      OP_DN_LEFT,
      OP_DN_RIGHT,
      OP_DN_DECIDE
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      rsp_load;
   } dp_cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic at_root;
      logic parent_less;
      logic leaf;
      logic has_right;
      logic keep;
   } dp_status_type;

endpackage

`default_nettype wire

@@ design/mhpq_if.sv @@
`default_nettype none

// request channel
interface mhpq_req_if;
   logic                               valid;
   logic                               ready;
   logic                               req_type;
   logic signed [mhpq_pkg::DATA_W-1:0] value;

   modport source (output valid, output req_type, output value, input ready);
   modport sink   (input valid, input req_type, input value, output ready);
endinterface

// result channel
interface mhpq_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [mhpq_pkg::DATA_W-1:0]  removed_value;
   logic signed [mhpq_pkg::DATA_W-1:0]  top_value;
   logic [mhpq_pkg::COUNT_W-1:0]        count;
   logic [mhpq_pkg::STATUS_W-1:0]       status;

   modport source (output valid, output removed_value, output top_value, output count,
                   output status, input ready);
   modport sink   (input valid, input removed_value, input top_value, input count,
                   input status, output ready);
endinterface

`default_nettype wire

@@ design/mhpq_datapath.sv @@
`default_nettype none

module mhpq_datapath #(
   parameter int DEPTH = mhpq_pkg::DEPTH_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire mhpq_pkg::dp_cmd_type                cmd,
   output mhpq_pkg::dp_status_type                  st,
   input  wire logic                                req_type,
   input  wire logic signed [mhpq_pkg::DATA_W-1:0]  req_value,
   output logic signed [mhpq_pkg::DATA_W-1:0]       rsp_removed_value,
   output logic signed [mhpq_pkg::DATA_W-1:0]       rsp_top_value,
   output logic [mhpq_pkg::COUNT_W-1:0]             rsp_count,
   output logic [mhpq_pkg::STATUS_W-1:0]            rsp_status
);

   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int CHILD_W = CNT_W + 1;
   localparam int DATA_W  = mhpq_pkg::DATA_W;

   // heap storage, slot k holds one-based position k+1
   logic signed [DATA_W-1:0] heap_ff [DEPTH];
   logic signed [DATA_W-1:0] rd_data_ff;

   logic [CNT_W-1:0]         count_ff, count_in;
   logic [CNT_W-1:0]         pos_ff, pos_in;
   logic [CNT_W-1:0]         best_ff, best_in;
   logic signed [DATA_W-1:0] mv_ff, mv_in;
   logic signed [DATA_W-1:0] bv_ff, bv_in;
   logic signed [DATA_W-1:0] removed_ff, removed_in;
   logic [mhpq_pkg::STATUS_W-1:0] status_ff, status_in;

   logic signed [DATA_W-1:0] rsp_removed_ff, rsp_top_ff;
   logic [mhpq_pkg::COUNT_W-1:0]  rsp_count_ff;
   logic [mhpq_pkg::STATUS_W-1:0] rsp_status_ff;

   logic [CHILD_W-1:0]       left_pos, right_pos, count_ext;
   logic [ADDR_W-1:0]        pos_addr, rd_addr, wr_addr;
   logic                     wr_en;
   logic signed [DATA_W-1:0] wr_data;

   // child positions of the current node
   assign left_pos  = {pos_ff, 1'b0};
   assign right_pos = {pos_ff, 1'b1};
   assign count_ext = CHILD_W'(count_ff);
   assign pos_addr  = ADDR_W'(pos_ff - CNT_W'(1));

   // status towards the controller
   assign st.full        = (count_ff == CNT_W'(DEPTH));
   assign st.empty       = (count_ff == '0);
   assign st.at_root     = (pos_ff == CNT_W'(1));
   assign st.parent_less = (rd_data_ff < mv_ff);
   assign st.leaf        = (left_pos > count_ext);
   assign st.has_right   = (right_pos <= count_ext);
   assign st.keep        = (best_ff == pos_ff);

   // memory port control; idle reads track the root
   always_comb begin
      rd_addr = '0;
      wr_en   = 1'b0;
      wr_addr = pos_addr;
      wr_data = mv_ff;
      case (cmd.op)
         mhpq_pkg::OP_UP_CHECK: begin
            if (st.at_root) begin
               wr_en = 1'b1;
            end else begin
               rd_addr = ADDR_W'((pos_ff >> 1) - CNT_W'(1));
            end
         end
         mhpq_pkg::OP_UP_CMP: begin
            wr_en = 1'b1;
            if (st.parent_less) begin
               wr_data = rd_data_ff;
            end
         end
         mhpq_pkg::OP_RM_LAST: begin
            rd_addr = ADDR_W'(count_ff - CNT_W'(1));
         end
         mhpq_pkg::OP_DN_CHECK: begin
            if (st.leaf) begin
               wr_en = 1'b1;
            end else begin
               rd_addr = ADDR_W'(left_pos - CHILD_W'(1));
            end
         end
         mhpq_pkg::OP_DN_LEFT: begin
            // right child sits in the slot after the left one
            rd_addr = ADDR_W'(left_pos);
         end
         mhpq_pkg::OP_DN_DECIDE: begin
            wr_en = 1'b1;
            if (!st.keep) begin
               wr_data = bv_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // next values of the working registers
   always_comb begin
      count_in   = count_ff;
      pos_in     = pos_ff;
      best_in    = best_ff;
      mv_in      = mv_ff;
      bv_in      = bv_ff;
      removed_in = removed_ff;
      status_in  = status_ff;
      case (cmd.op)
         mhpq_pkg::OP_START: begin
            mv_in      = req_value;
            removed_in = '0;
            status_in  = mhpq_pkg::STATUS_OK;
            if (req_type == mhpq_pkg::REQ_INSERT) begin
               if (st.full) begin
                  status_in = mhpq_pkg::STATUS_OVERFLOW;
               end else begin
                  count_in = count_ff + CNT_W'(1);
                  pos_in   = count_ff + CNT_W'(1);
               end
            end else if (st.empty) begin
               status_in = mhpq_pkg::STATUS_UNDERFLOW;
            end
         end
         mhpq_pkg::OP_UP_CMP: begin
            if (st.parent_less) begin
               pos_in = pos_ff >> 1;
            end
         end
         mhpq_pkg::OP_RM_LAST: begin
            removed_in = rd_data_ff;
            count_in   = count_ff - CNT_W'(1);
            pos_in     = CNT_W'(1);
         end
         mhpq_pkg::OP_RM_MOVE: begin
            mv_in = rd_data_ff;
         end
         mhpq_pkg::OP_DN_LEFT: begin
            if (mv_ff < rd_data_ff) begin
               best_in = CNT_W'(left_pos);
               bv_in   = rd_data_ff;
            end else begin
               best_in = pos_ff;
               bv_in   = mv_ff;
            end
         end
         mhpq_pkg::OP_DN_RIGHT: begin
            if (bv_ff < rd_data_ff) begin
               best_in = CNT_W'(right_pos);
               bv_in   = rd_data_ff;
            end
         end
         mhpq_pkg::OP_DN_DECIDE: begin
            if (!st.keep) begin
               pos_in = best_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // hold the element count
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // advance the working registers
   always_ff @(posedge clock) begin
      pos_ff     <= pos_in;
      best_ff    <= best_in;
      mv_ff      <= mv_in;
      bv_ff      <= bv_in;
      removed_ff <= removed_in;
      status_ff  <= status_in;
   end

   // heap memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         heap_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= heap_ff[rd_addr];
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_removed_ff <= removed_ff;
         rsp_top_ff     <= st.empty ? '0 : rd_data_ff;
         rsp_count_ff   <= mhpq_pkg::COUNT_W'(count_ff);
         rsp_status_ff  <= status_ff;
      end
   end

   assign rsp_removed_value = rsp_removed_ff;
   assign rsp_top_value     = rsp_top_ff;
   assign rsp_count         = rsp_count_ff;
   assign rsp_status        = rsp_status_ff;

endmodule

`default_nettype wire

@@ design/mhpq_ctrl.sv @@
`default_nettype none

module mhpq_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   input  wire logic                    req_type,
   output logic                         req_ready,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   input  wire mhpq_pkg::dp_status_type st,
   output mhpq_pkg::dp_cmd_type         cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_UP_CHECK,
      S_UP_CMP,
      S_RM_LAST,
      S_RM_MOVE,
      S_DN_CHECK,
      S_DN_LEFT,
      S_DN_RIGHT,
      S_DN_DECIDE,
      S_TOP,
      S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // sequence the sift and issue datapath operations
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd.op       = mhpq_pkg::OP_NONE;
      cmd.rsp_load = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op = mhpq_pkg::OP_START;
               if (req_type == mhpq_pkg::REQ_INSERT) begin
                  state_in = st.full ? S_DONE : S_UP_CHECK;
               end else begin
                  state_in = st.empty ? S_DONE : S_RM_LAST;
               end
            end
         end
         S_UP_CHECK: begin
            cmd.op   = mhpq_pkg::OP_UP_CHECK;
            state_in = st.at_root ? S_TOP : S_UP_CMP;
         end
         S_UP_CMP: begin
            cmd.op   = mhpq_pkg::OP_UP_CMP;
            state_in = st.parent_less ? S_UP_CHECK : S_TOP;
         end
         S_RM_LAST: begin
            cmd.op   = mhpq_pkg::OP_RM_LAST;
            state_in = S_RM_MOVE;
         end
         S_RM_MOVE: begin
            cmd.op   = mhpq_pkg::OP_RM_MOVE;
            state_in = st.empty ? S_DONE : S_DN_CHECK;
         end
         S_DN_CHECK: begin
            cmd.op   = mhpq_pkg::OP_DN_CHECK;
            state_in = st.leaf ? S_TOP : S_DN_LEFT;
         end
         S_DN_LEFT: begin
            cmd.op   = mhpq_pkg::OP_DN_LEFT;
            state_in = st.has_right ? S_DN_RIGHT : S_DN_DECIDE;
         end
         S_DN_RIGHT: begin
            cmd.op   = mhpq_pkg::OP_DN_RIGHT;
            state_in = S_DN_DECIDE;
         end
         S_DN_DECIDE: begin
            cmd.op   = mhpq_pkg::OP_DN_DECIDE;
            state_in = st.keep ? S_TOP : S_DN_CHECK;
         end
         S_TOP: begin
            // root read in flight
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // hold state and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

@@ design/max_heap_priority_queue.sv @@
// Binary max-heap priority queue of signed 32-bit values, DEPTH entries deep, held in a
// single-port-read, single-port-write memory. An insert (req_type 0) places the value after
// the last element and sifts it up; a removal (req_type 1) returns the maximum, moves the last
// element to the root and sifts it down towards the larger child, the left one on a tie.
// Each request gives one result: the removed maximum (zero otherwise), the new top (zero when
// empty), the count and a status (ok, overflow on a full insert, underflow on an empty
// removal). One request is worked at a time. Every memory read has a registered output, so
// each sift level costs one read and a compare for an insert and up to two reads, a compare
// pair and a write for a removal. A removal that empties the heap does no sift, and a
// rejected request goes straight to its result. The next request is taken while a finished
// result still waits in the output register. No clearing pass follows reset: only values
// from slots below the count are ever used.
`default_nettype none

module max_heap_priority_queue #(
   parameter int DEPTH = mhpq_pkg::DEPTH_DEFAULT
) (
   input  wire logic   clock,
   input  wire logic   reset,
   mhpq_req_if.sink    req_ch,
   mhpq_rsp_if.source  rsp_ch
);

   mhpq_pkg::dp_cmd_type    cmd;
   mhpq_pkg::dp_status_type st;

   // sequencing
   mhpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_type  (req_ch.req_type),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .st        (st),
      .cmd       (cmd)
   );

   // heap memory and working registers
   mhpq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .st                (st),
      .req_type          (req_ch.req_type),
      .req_value         (req_ch.value),
      .rsp_removed_value (rsp_ch.removed_value),
      .rsp_top_value     (rsp_ch.top_value),
      .rsp_count         (rsp_ch.count),
      .rsp_status        (rsp_ch.status)
   );

endmodule

`default_nettype wire

@@ design/mhpq_checker.sv @@
`default_nettype none

module mhpq_checker #(
   parameter int DEPTH = mhpq_pkg::DEPTH_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                rsp_valid,
   input  wire logic                                rsp_ready,
   input  wire logic signed [mhpq_pkg::DATA_W-1:0]  rsp_removed_value,
   input  wire logic signed [mhpq_pkg::DATA_W-1:0]  rsp_top_value,
   input  wire logic [mhpq_pkg::COUNT_W-1:0]        rsp_count,
   input  wire logic [mhpq_pkg::STATUS_W-1:0]       rsp_status
);

   // the count field shows the full count only when it fits
   localparam bit COUNT_EXACT = DEPTH < (1 << mhpq_pkg::COUNT_W);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_top_value) && $stable(rsp_status))
      else $error("result dropped or changed while stalled");

   // an empty heap shows a zero top
   a_empty_top: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && COUNT_EXACT && rsp_count == '0 |-> rsp_top_value == '0)
      else $error("non-zero top on an empty heap");

   // underflow only on an empty heap, nothing removed
   a_underflow: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == mhpq_pkg::STATUS_UNDERFLOW
      |-> rsp_removed_value == '0 && (!COUNT_EXACT || rsp_count == '0))
      else $error("underflow with elements held or a value removed");

   // overflow only on a full heap
   a_overflow: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == mhpq_pkg::STATUS_OVERFLOW
      |-> rsp_count == mhpq_pkg::COUNT_W'(DEPTH) && rsp_removed_value == '0)
      else $error("overflow reported below full");

   // no result straight out of reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind max_heap_priority_queue mhpq_checker #(
   .DEPTH (DEPTH)
) u_mhpq_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_removed_value (rsp_ch.removed_value),
   .rsp_top_value     (rsp_ch.top_value),
   .rsp_count         (rsp_ch.count),
   .rsp_status        (rsp_ch.status)
);

`default_nettype wire

@@ tb/mhpq_tb_pkg.sv @@
package mhpq_tb_pkg;
   import mhpq_pkg::*;

   // one result transfer, field by field
   typedef struct packed {
      logic signed [DATA_W-1:0] removed_value;
      logic signed [DATA_W-1:0] top_value;
      logic [COUNT_W-1:0]       count;
      logic [STATUS_W-1:0]      status;
   } heap_result_t;

   // shadow max-heap and the queue of results it predicts
   class heap_scoreboard;
      logic signed [DATA_W-1:0] heap_slots [DEPTH_DEFAULT];
      int                       held;
      heap_result_t             awaited [$];
      int                       errors;
      int                       shown;

      function new();
         held   = 0;
         errors = 0;
         shown  = 0;
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      // climb from the last slot while the parent is strictly smaller
      function void raise_last();
         int                       pos;
         int                       parent;
         logic signed [DATA_W-1:0] spare;
         pos = held;
         while (pos > 1) begin
            parent = pos / 2;
            if (heap_slots[parent-1] < heap_slots[pos-1]) begin
               spare                = heap_slots[parent-1];
               heap_slots[parent-1] = heap_slots[pos-1];
               heap_slots[pos-1]    = spare;
               pos                  = parent;
            end else begin
               break;
            end
         end
      endfunction

      // sink the root towards the larger child, the left one on a tie
      function void sink_root();
         int                       pos;
         int                       best;
         logic signed [DATA_W-1:0] spare;
         pos = 1;
         forever begin
            best = pos;
            if (2*pos <= held && heap_slots[best-1] < heap_slots[2*pos-1])
               best = 2*pos;
            if (2*pos+1 <= held && heap_slots[best-1] < heap_slots[2*pos])
               best = 2*pos + 1;
            if (best == pos)
               break;
            spare              = heap_slots[pos-1];
            heap_slots[pos-1]  = heap_slots[best-1];
            heap_slots[best-1] = spare;
            pos                = best;
         end
      endfunction

      // apply an accepted request to the shadow heap and queue its result
      function void note_request(logic kind, logic signed [DATA_W-1:0] value);
         heap_result_t want;
         want        = '0;
         want.status = STATUS_OK;
         if (kind == REQ_INSERT) begin
            if (held >= DEPTH_DEFAULT) begin
               want.status = STATUS_OVERFLOW;
            end else begin
               heap_slots[held] = value;
               held++;
               raise_last();
            end
         end else begin
            if (held == 0) begin
               want.status = STATUS_UNDERFLOW;
            end else begin
               want.removed_value = heap_slots[0];
               heap_slots[0]      = heap_slots[held-1];
               held--;
               sink_root();
            end
         end
         want.top_value = (held > 0) ? heap_slots[0] : '0;
         want.count     = COUNT_W'(held);
         awaited.push_back(want);
      endfunction

      task report(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
         errors++;
         if (shown < 40)
            $display("mismatch on %s: got %h, want %h", what, got, want);
         shown++;
      endtask

      // compare a result transfer with the oldest prediction
      task check_result(heap_result_t got);
         heap_result_t want;
         if (awaited.size() == 0) begin
            report("result with nothing awaited", got.top_value, '0);
         end else begin
            want = awaited.pop_front();
            if (got.removed_value !== want.removed_value)
               report("removed_value", got.removed_value, want.removed_value);
            if (got.top_value !== want.top_value)
               report("top_value", got.top_value, want.top_value);
            if (got.count !== want.count)
               report("count", DATA_W'(got.count), DATA_W'(want.count));
            if (got.status !== want.status)
               report("status", DATA_W'(got.status), DATA_W'(want.status));
         end
      endtask
   endclass

endpackage

@@ tb/tb_max_heap_priority_queue.sv @@
module tb_max_heap_priority_queue;
   timeunit 1ns;
   timeprecision 1ps;

   import mhpq_pkg::*;
   import mhpq_tb_pkg::*;

   localparam int RANDOM_ITEMS = 1950;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int IDLE_PCT     = 21;
   localparam int FILL         = 0;
   localparam int DRAIN        = 1;
   localparam int BALANCED     = 2;
   localparam int CHURN        = 3;

   localparam logic signed [DATA_W-1:0] MOST_NEG = {1'b1, {(DATA_W-1){1'b0}}};
   localparam logic signed [DATA_W-1:0] MOST_POS = {1'b0, {(DATA_W-1){1'b1}}};

   logic clock;
   logic reset;
   bit   steady;
   int   cycles;
   int   sent;

   mhpq_req_if req_ch ();
   mhpq_rsp_if rsp_ch ();

   heap_scoreboard heap_check = new();

   max_heap_priority_queue DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // offer one request, with a random gap first, and hold it until the transfer
   task automatic send_request(logic kind, logic signed [DATA_W-1:0] value);
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.req_type <= kind;
      req_ch.value    <= value;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
      heap_check.note_request(kind, value);
      sent++;
   endtask

   // hold off until every predicted result has arrived
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (heap_check.pending() != 0)
         @(posedge clock);
   endtask

   // values biased towards duplicates and the ends of the range
   function automatic logic signed [DATA_W-1:0] pick_value();
      logic signed [DATA_W-1:0] v;
      case ($urandom_range(9))
         0, 1: v = $urandom_range(7) - 3;
         2: begin
            case ($urandom_range(3))
               0: v = MOST_NEG;
               1: v = MOST_POS;
               2: v = '0;
               default: v = '1;
            endcase
         end
         3: v = $urandom_range(1) ? MOST_POS - $urandom_range(3) : MOST_NEG + $urandom_range(3);
         default: v = $urandom();
      endcase
      return v;
   endfunction

   // result side: random stalls, check every transfer
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready)
            heap_check.check_result({rsp_ch.removed_value, rsp_ch.top_value,
                                     rsp_ch.count, rsp_ch.status});
         rsp_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // stop a hung run
   initial begin
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   // stimulus
   initial begin
      int mode;
      int burst;
      int insert_pct;
      int target;
      logic kind;

      sent            = 0;
      steady          = 1'b0;
      reset           <= 1'b1;
      req_ch.valid    <= 1'b0;
      req_ch.req_type <= REQ_INSERT;
      req_ch.value    <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty removal, range extremes, equal values, drain past empty
      send_request(REQ_REMOVE, MOST_POS);
      send_request(REQ_INSERT, MOST_NEG);
      send_request(REQ_REMOVE, '0);
      send_request(REQ_INSERT, '0);
      send_request(REQ_INSERT, MOST_POS);
      send_request(REQ_INSERT, MOST_NEG);
      send_request(REQ_INSERT, '1);
      send_request(REQ_INSERT, 7);
      send_request(REQ_INSERT, 7);
      send_request(REQ_INSERT, 7);
      send_request(REQ_INSERT, 32'sh4000_0000);
      repeat (8) send_request(REQ_REMOVE, $urandom());
      send_request(REQ_REMOVE, MOST_NEG);
      wait_drained();

      // random: bursts that fill, drain, churn or mix the heap
      target = sent + RANDOM_ITEMS;
      mode   = FILL;
      while (sent < target) begin
         burst = (mode == FILL || mode == DRAIN) ? $urandom_range(60, 100)
                                                 : $urandom_range(20, 60);
         case (mode)
            FILL:     insert_pct = 90;
            DRAIN:    insert_pct = 12;
            BALANCED: insert_pct = 55;
            default:  insert_pct = 70;
         endcase
         for (int k = 0; k < burst && sent < target; k++) begin
            steady = (sent >= 900 && sent < 1200);
            kind   = ($urandom_range(99) < insert_pct) ? REQ_INSERT : REQ_REMOVE;
            send_request(kind, pick_value());
         end
         if ($urandom_range(4) == 0)
            wait_drained();
         mode = $urandom_range(3);
      end
      steady = 1'b0;

      // drain, then let the block settle
      wait_drained();
      repeat (40) @(posedge clock);
      if (heap_check.errors == 0 && heap_check.pending() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
